### rtl/core/qr_byte_mode_codeword_builder_macros.svh
// Assertion helpers for the codeword builder checker.
`ifndef QR_BYTE_MODE_CODEWORD_BUILDER_MACROS_SVH
`define QR_BYTE_MODE_CODEWORD_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QRBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/qrbm_pkg.sv
`default_nettype none
package qrbm_pkg;

  localparam int DATA_CODEWORDS = 55;
  localparam int MAX_LEN        = DATA_CODEWORDS - 2;
  localparam int SENT_W         = $clog2(DATA_CODEWORDS + 1);

  localparam logic [3:0] MODE_NIBBLE = 4'h4;
  localparam logic [7:0] PAD_FIRST   = 8'hEC;
  localparam logic [7:0] PAD_SECOND  = 8'h11;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TERM,
    ST_PAD
  } state_e;

  typedef struct packed {
    logic load_in;
    logic load_term;
    logic load_pad;
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
    logic finish;    // current input item ends its message
    logic done;      // next codeword reaches capacity
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/qr_byte_mode_codeword_builder.sv
// QR byte-mode data codeword builder, capacity of DATA_CODEWORDS codewords.
// Input channel (in_valid_i / in_stall_o): a beat with mode_i = 0 starts a
// message of message_length_i bytes; a beat with mode_i = 1 carries one byte.
// Output channel (out_valid_o / out_stall_i): one codeword per beat, with
// last_codeword_o on the final one and error_o on an error beat (codeword 0).
// Latency: the codeword for an accepted beat is valid the next cycle.
// Throughput: one input beat per cycle while message bytes stream and out_stall_i
// is low. The beat that ends a message (last byte, or a start with length 0) is
// followed by the terminator and pad codewords, one per cycle while out_stall_i is
// low, up to capacity; the sequencer holds in_stall_o high during that burst.
// A length above DATA_CODEWORDS - 2 gives a single error beat.
// When the receiver stalls, the output register holds its beat and the input
// side stalls too; nothing is dropped.
// Reset (rst_ni low, asynchronous) clears the message state, empties the
// output register and returns the sequencer to idle.
`default_nettype none
module qr_byte_mode_codeword_builder import qrbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] message_length_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] codeword_o,
  output logic       last_codeword_o,
  output logic       error_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: idle accepts beats, then walks terminator and pads.
  qrbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Message state, codeword formation and the output register.
  qrbm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .message_length_i (message_length_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .codeword_o       (codeword_o),
    .last_codeword_o  (last_codeword_o),
    .error_o          (error_o)
  );

endmodule
`default_nettype wire

### rtl/core/qrbm_datapath.sv
`default_nettype none
module qrbm_datapath import qrbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       mode_i,
  input  logic [7:0] message_length_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] codeword_o,
  output logic       last_codeword_o,
  output logic       error_o
);

  localparam logic [SENT_W:0] CAP   = (SENT_W + 1)'(DATA_CODEWORDS);
  localparam logic [7:0]      LEN_M = 8'(MAX_LEN);

  logic [3:0]        held_q, held_d;
  logic [7:0]        rem_q, rem_d;
  logic [SENT_W-1:0] sent_q, sent_d;
  logic              active_q, active_d;
  logic              pad_sel_q, pad_sel_d;
  logic              valid_q, valid_d;
  logic [7:0]        cw_q, cw_d;
  logic              last_q, last_d;
  logic              err_q, err_d;

  logic [SENT_W:0]   sent_inc;
  logic              len_bad;
  logic              byte_bad;

  assign sent_inc = {1'b0, sent_q} + (SENT_W + 1)'(1);
  assign len_bad  = (message_length_i > LEN_M);
  assign byte_bad = !active_q || (rem_q == 8'd0);

  assign sts_o.out_free = !valid_q || !out_stall_i;
  assign sts_o.done     = (sent_inc >= CAP);
  assign sts_o.finish   = (mode_i == MODE_START) ? (!len_bad && (message_length_i == 8'd0))
                                                 : (!byte_bad && (rem_q == 8'd1));

  always_comb begin
    held_d    = held_q;
    rem_d     = rem_q;
    sent_d    = sent_q;
    active_d  = active_q;
    pad_sel_d = pad_sel_q;
    valid_d   = valid_q && out_stall_i;
    cw_d      = cw_q;
    last_d    = last_q;
    err_d     = err_q;

    if (cmd_i.load_in) begin
      valid_d = 1'b1;
      if (mode_i == MODE_START) begin
        if (len_bad) begin
          {cw_d, last_d, err_d} = {8'h00, 1'b0, 1'b1};
          held_d   = 4'h0;
          rem_d    = 8'd0;
          sent_d   = '0;
          active_d = 1'b0;
        end else begin
          cw_d     = {MODE_NIBBLE, message_length_i[7:4]};
          last_d   = 1'b0;
          err_d    = 1'b0;
          held_d   = message_length_i[3:0];
          rem_d    = message_length_i;
          sent_d   = SENT_W'(1);
          active_d = 1'b1;
        end
      end else begin
        if (byte_bad) begin
          {cw_d, last_d, err_d} = {8'h00, 1'b0, 1'b1};
        end else begin
          cw_d   = {held_q, data_byte_i[7:4]};
          last_d = (sent_inc >= CAP);
          err_d  = 1'b0;
          held_d = data_byte_i[3:0];
          rem_d  = rem_q - 8'd1;
          sent_d = sent_inc[SENT_W-1:0];
        end
      end
    end else if (cmd_i.load_term) begin
      valid_d   = 1'b1;
      cw_d      = {held_q, 4'h0};
      last_d    = (sent_inc >= CAP);
      err_d     = 1'b0;
      sent_d    = sent_inc[SENT_W-1:0];
      held_d    = 4'h0;
      rem_d     = 8'd0;
      active_d  = 1'b0;
      pad_sel_d = 1'b0;
    end else if (cmd_i.load_pad) begin
      valid_d   = 1'b1;
      cw_d      = pad_sel_q ? PAD_SECOND : PAD_FIRST;
      last_d    = (sent_inc >= CAP);
      err_d     = 1'b0;
      sent_d    = sent_inc[SENT_W-1:0];
      pad_sel_d = !pad_sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 4'h0;
      rem_q     <= 8'd0;
      sent_q    <= '0;
      active_q  <= 1'b0;
      pad_sel_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      held_q    <= held_d;
      rem_q     <= rem_d;
      sent_q    <= sent_d;
      active_q  <= active_d;
      pad_sel_q <= pad_sel_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q   <= cw_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_valid_o     = valid_q;
  assign codeword_o      = cw_q;
  assign last_codeword_o = last_q;
  assign error_o         = err_q;

endmodule
`default_nettype wire

### rtl/core/qrbm_ctrl.sv
`default_nettype none
module qrbm_ctrl import qrbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.finish) state_d = ST_TERM;
      end
      ST_TERM: begin
        if (sts_i.out_free) state_d = sts_i.done ? ST_IDLE : ST_PAD;
      end
      ST_PAD: begin
        if (sts_i.out_free && sts_i.done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = !sts_i.out_free;
        cmd_o.load_in = in_valid_i && sts_i.out_free;
      end
      ST_TERM: cmd_o.load_term = sts_i.out_free;
      ST_PAD:  cmd_o.load_pad  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/qrbm_checker.sv
`default_nettype none
`include "qr_byte_mode_codeword_builder_macros.svh"
module qrbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] codeword_o,
  input logic       last_codeword_o,
  input logic       error_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  `QRBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(codeword_o) && $stable(last_codeword_o) && $stable(error_o), "stalled output beat changed")
  `QRBM_ASSERT_SAME(a_err_clean, clk_i, rst_ni, out_valid_o && error_o, codeword_o == 8'h00 && !last_codeword_o, "error beat with codeword or last set")
  `QRBM_ASSERT_SAME(a_back_press, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o, "input taken while output is stalled")
  `QRBM_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_beat, out_valid_o, "accepted beat produced no result")

endmodule

bind qr_byte_mode_codeword_builder qrbm_checker u_qrbm_checker (.*);
`default_nettype wire

### sim/qr_byte_mode_codeword_checker.sv
`timescale 1ns / 1ps
module qr_byte_mode_codeword_checker import qrbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       mode_i,
  input  logic [7:0] message_length_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] codeword_i,
  input  logic       last_codeword_i,
  input  logic       error_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] codeword;
    logic       last;
    logic       err;
  } codeword_beat_t;

  localparam int             REPORT_LIMIT = 10;
  localparam codeword_beat_t ERROR_BEAT   = '{codeword: 8'h00, last: 1'b0, err: 1'b1};

  codeword_beat_t codeword_q[$];
  logic [3:0]     held_nibble;
  logic [7:0]     bytes_left;
  logic [5:0]     sent_count;
  logic           in_message;
  int             burst_len;  // codewords produced by the current input beat
  int             mismatches = 0;

  assign mismatch_count_o = mismatches;

  // append one predicted beat at the tail of the queue
  task automatic queue_beat(input codeword_beat_t beat);
    codeword_q = {codeword_q, beat};
  endtask

  task automatic clear_message();
    held_nibble = '0;
    bytes_left  = '0;
    sent_count  = '0;
    in_message  = 1'b0;
  endtask

  task automatic emit_codeword(input logic [7:0] cw);
    codeword_beat_t beat;
    sent_count    = sent_count + 6'd1;
    beat.codeword = cw;
    beat.last     = (sent_count >= DATA_CODEWORDS);
    beat.err      = 1'b0;
    queue_beat(beat);
    burst_len++;
  endtask

  // terminator nibble, then alternating pads up to capacity
  task automatic close_message();
    logic pad_second;
    pad_second = 1'b0;
    emit_codeword({held_nibble, 4'h0});
    while (sent_count < DATA_CODEWORDS && burst_len < DATA_CODEWORDS) begin
      emit_codeword(pad_second ? PAD_SECOND : PAD_FIRST);
      pad_second = !pad_second;
    end
    held_nibble = '0;
    bytes_left  = '0;
    in_message  = 1'b0;
  endtask

  task automatic predict_codewords(input logic m, input logic [7:0] len, input logic [7:0] b);
    burst_len = 0;
    if (m == MODE_START) begin
      if (len > MAX_LEN) begin
        // oversize length drops any message in progress
        clear_message();
        queue_beat(ERROR_BEAT);
      end else begin
        sent_count = '0;
        in_message = 1'b1;
        bytes_left = len;
        emit_codeword({MODE_NIBBLE, len[7:4]});
        held_nibble = len[3:0];
        if (bytes_left == 8'd0) close_message();
      end
    end else if (!in_message || bytes_left == 8'd0) begin
      queue_beat(ERROR_BEAT);
    end else begin
      emit_codeword({held_nibble, b[7:4]});
      held_nibble = b[3:0];
      bytes_left  = bytes_left - 8'd1;
      if (bytes_left == 8'd0) close_message();
    end
  endtask

  task automatic check_beat();
    codeword_beat_t want;
    if (codeword_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected beat codeword=%02h last=%0b error=%0b",
                 $time, codeword_i, last_codeword_i, error_i);
      return;
    end
    want = codeword_q.pop_front();
    if (codeword_i !== want.codeword || last_codeword_i !== want.last ||
        error_i !== want.err) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: codeword exp %02h/%0b/%0b got %02h/%0b/%0b (codeword/last/error)",
                 $time, want.codeword, want.last, want.err,
                 codeword_i, last_codeword_i, error_i);
    end
  endtask

  // output side is checked first: a result never comes from a beat taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_message();
      codeword_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_beat();
      if (in_valid_i && !in_stall_i) predict_codewords(mode_i, message_length_i, data_byte_i);
    end
    pending_o <= codeword_q.size();
  end

endmodule

### sim/tb_qr_byte_mode_codeword_builder.sv
`timescale 1ns / 1ps
module tb_qr_byte_mode_codeword_builder;
  import qrbm_pkg::*;

  localparam int RANDOM_ITEMS   = 420;
  localparam int IDLE_PERCENT   = 38;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES   = 8;     // output is registered, plenty of margin
  localparam int STEADY_FROM    = 150;   // no-idle window, in accepted input beats
  localparam int STEADY_TO      = 270;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic       mode           = MODE_START;
  logic [7:0] message_length = 8'h00;
  logic [7:0] data_byte      = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] codeword;
  logic       last_codeword;
  logic       error;

  logic       steady         = 1'b0;  // both sides stop idling while set
  int         items_sent     = 0;
  int         quiet_cycles   = 0;
  int         mismatches;
  int         pending;

  qr_byte_mode_codeword_builder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .message_length_i (message_length),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .codeword_o       (codeword),
    .last_codeword_o  (last_codeword),
    .error_o          (error)
  );

  // Predicts the codeword stream from accepted input beats and scores each output beat.
  qr_byte_mode_codeword_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .message_length_i (message_length),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .codeword_i       (codeword),
    .last_codeword_i  (last_codeword),
    .error_i          (error),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, none inside the steady window.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Watchdog: count cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one beat and hold it until it is taken. Idle cycles are only
  // inserted before a beat, so valid never drops while a beat is pending and
  // is never lowered and raised in the same step.
  task automatic send_beat(input logic m, input logic [7:0] len, input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    message_length <= len;
    data_byte      <= b;
    // in_stall is read before the edge updates land, i.e. the value the DUT saw
    do @(posedge clk); while (in_stall);
    items_sent++;
    steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
  endtask

  // Well-formed message: start beat with a don't-care data byte, then len bytes
  // whose length field is noise.
  task automatic send_message(input logic [7:0] len);
    send_beat(MODE_START, len, 8'($urandom_range(255)));
    for (int i = 0; i < len; i++)
      send_beat(MODE_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Mostly short messages so the run sees many headers and pad bursts;
  // a fair share of full-capacity ones for the exact-fit case.
  function automatic logic [7:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 8'($urandom_range(0, 6));
    if (roll < 85) return 8'($urandom_range(7, MAX_LEN));
    return 8'(MAX_LEN);
  endfunction

  initial begin
    int         roll;
    logic [7:0] len;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // byte with no message open: error, state untouched
    send_beat(MODE_BYTE, 8'hFF, 8'hFF);
    // empty message: header, terminator and full pad run from one beat
    send_beat(MODE_START, 8'h00, 8'hFF);
    // just over capacity and the largest length: both flagged
    send_beat(MODE_START, 8'(MAX_LEN + 1), 8'h00);
    send_beat(MODE_START, 8'hFF, 8'hFF);
    // one-byte and two-byte messages, field extremes
    send_beat(MODE_START, 8'h01, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'hFF);
    send_beat(MODE_START, 8'h02, 8'h00);
    send_beat(MODE_BYTE, 8'hFF, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'hA5);
    // new start aborts a message in flight
    send_beat(MODE_START, 8'h05, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'h3C);
    send_beat(MODE_START, 8'h01, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'h5A);
    // stray byte after a finished message
    send_beat(MODE_BYTE, 8'h00, 8'h77);
    // oversize start drops the open message; the next byte is stray
    send_beat(MODE_START, 8'h03, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'h12);
    send_beat(MODE_START, 8'd200, 8'h00);
    send_beat(MODE_BYTE, 8'h00, 8'h34);

    // --- random ---
    // exact fit (terminator lands on the last slot) and one short of it first
    send_message(8'(MAX_LEN));
    send_message(8'(MAX_LEN - 1));
    while (items_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_message(pick_length());
      end else if (roll < 85) begin
        // truncated message; whatever comes next aborts or continues it
        len = 8'($urandom_range(2, 20));
        send_beat(MODE_START, len, 8'($urandom_range(255)));
        repeat ($urandom_range(0, len - 1))
          send_beat(MODE_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (roll < 93) begin
        send_beat(MODE_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        send_beat(MODE_START, 8'($urandom_range(MAX_LEN + 1, 255)), 8'($urandom_range(255)));
      end
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // drain: pending is registered in the checker, so step before looking
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
